// File: src/best_fit_owner_allocator_core_assert.svh
// Assertion macros used by the allocator datapath.
`ifndef BEST_FIT_OWNER_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_OWNER_ALLOCATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BFOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BFOA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BFOA_ASSERT(lbl, prop, msg)
`define BFOA_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// File: src/bfoa_pkg.sv
// Types, constants and codes shared by the best-fit owner allocator.
package bfoa_pkg;

  localparam int MEM_UNITS = 64;
  localparam int IDX_W     = $clog2(MEM_UNITS);
  localparam int POS_W     = $clog2(MEM_UNITS + 1);
  localparam int SUM_W     = POS_W + 1;
  localparam int OWNER_W   = 16;
  localparam int SIZE_W    = 7;
  localparam int START_W   = 6;
  localparam int FREED_W   = 7;
  localparam int CMP_W     = ((POS_W > SIZE_W) ? POS_W : SIZE_W) + 1;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [FREED_W-1:0] FREED_MAX = '1;
  localparam logic [0:0] REG_FREE_ON_FAIL = 1'b0;
  localparam logic FREE_ON_FAIL_RST = 1'b1;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef struct packed {
    action_e              action;
    logic [OWNER_W-1:0]   owner_id;
    logic [SIZE_W-1:0]    request_size;
  } item_t;

  typedef struct packed {
    logic                 granted;
    logic [START_W-1:0]   start_unit;
    logic [FREED_W-1:0]   units_freed;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MARK,
    ST_RELEASE,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic scan_step;
    logic mark_step;
    logic rel_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic mark_go;
    logic rel_done;
  } dp_sts_t;

endpackage

// File: src/bfoa_datapath.sv
// Datapath: unit map, owner memory, best-fit scan, marking and release.
`include "best_fit_owner_allocator_core_assert.svh"

module bfoa_datapath
  import bfoa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output logic    res_valid_o,
  output result_t result_o
);

  logic [MEM_UNITS-1:0] occ_q, occ_d;
  logic [OWNER_W-1:0]   mem [MEM_UNITS];
  logic [OWNER_W-1:0]   rd_data_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 rd_valid_q, rd_valid_d;
  logic                 rd_en;

  item_t                item_q;
  logic [POS_W-1:0]     idx_q, idx_d;
  logic [POS_W-1:0]     run_len_q, run_len_d;
  logic [IDX_W-1:0]     run_start_q, run_start_d;
  logic [POS_W-1:0]     best_len_q, best_len_d;
  logic [IDX_W-1:0]     best_start_q, best_start_d;
  logic                 found_q, found_d;
  logic [POS_W-1:0]     count_q, count_d;
  logic                 res_valid_q;
  result_t              res_q;

  logic                 in_range;
  logic                 unit_free;
  logic                 run_fits;
  logic [SUM_W-1:0]     mark_sum;
  logic [IDX_W-1:0]     mark_addr;
  logic                 mark_go;
  logic                 hit;
  logic                 granted;

  assign in_range  = idx_q < POS_W'(MEM_UNITS);
  assign unit_free = in_range && !occ_q[idx_q[IDX_W-1:0]];
  assign run_fits  = (run_len_q != '0)
                  && (CMP_W'(run_len_q) >= CMP_W'(item_q.request_size))
                  && (!found_q || (run_len_q < best_len_q));

  assign mark_sum  = SUM_W'(best_start_q) + SUM_W'(idx_q);
  assign mark_addr = mark_sum[IDX_W-1:0];
  assign mark_go   = (CMP_W'(idx_q) < CMP_W'(item_q.request_size))
                  && (mark_sum < SUM_W'(MEM_UNITS));

  assign hit   = rd_valid_q && occ_q[rd_idx_q] && (rd_data_q == item_q.owner_id);
  assign rd_en = cmd_i.rel_step && in_range;

  always_comb begin
    occ_d        = occ_q;
    idx_d        = idx_q;
    run_len_d    = run_len_q;
    run_start_d  = run_start_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    found_d      = found_q;
    count_d      = count_q;
    rd_valid_d   = rd_en;

    if (cmd_i.load) begin
      idx_d     = '0;
      run_len_d = '0;
      found_d   = 1'b0;
      count_d   = '0;
    end else if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.scan_step) begin
      // The index parks at MEM_UNITS, where the last run is closed.
      if (in_range) begin
        idx_d = idx_q + POS_W'(1);
      end
      if (unit_free) begin
        if (run_len_q == '0) begin
          run_start_d = idx_q[IDX_W-1:0];
        end
        run_len_d = run_len_q + POS_W'(1);
      end else begin
        if (run_fits) begin
          found_d      = 1'b1;
          best_len_d   = run_len_q;
          best_start_d = run_start_q;
        end
        run_len_d = '0;
      end
    end else if (cmd_i.mark_step) begin
      occ_d[mark_addr] = 1'b1;
      idx_d = idx_q + POS_W'(1);
    end else if (rd_en) begin
      idx_d = idx_q + POS_W'(1);
    end

    // The compare stage works on the registered read, in the cycle after the memory read.
    if (hit) begin
      occ_d[rd_idx_q] = 1'b0;
      count_d = count_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      idx_q       <= '0;
      run_len_q   <= '0;
      found_q     <= 1'b0;
      count_q     <= '0;
      rd_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      idx_q       <= idx_d;
      run_len_q   <= run_len_d;
      found_q     <= found_d;
      count_q     <= count_d;
      rd_valid_q  <= rd_valid_d;
      res_valid_q <= cmd_i.emit;
    end
  end

  assign granted = found_q && (item_q.action == ACT_ALLOC);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    run_start_q  <= run_start_d;
    best_len_q   <= best_len_d;
    best_start_q <= best_start_d;
    rd_idx_q     <= idx_q[IDX_W-1:0];
    if (cmd_i.emit) begin
      res_q.granted     <= granted;
      res_q.start_unit  <= granted ? START_W'(best_start_q) : '0;
      res_q.units_freed <= (count_q > POS_W'(FREED_MAX)) ? FREED_MAX : FREED_W'(count_q);
    end
  end

  // Owner memory: one write port for marking, one registered read for release.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_step) begin
      mem[mark_addr] <= item_q.owner_id;
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q[IDX_W-1:0]];
    end
  end

  assign sts_o.scan_last = (idx_q == POS_W'(MEM_UNITS));
  assign sts_o.found     = found_q;
  assign sts_o.mark_go   = mark_go;
  assign sts_o.rel_done  = !in_range && !rd_valid_q;

  assign res_valid_o = res_valid_q;
  assign result_o    = res_q;

  `BFOA_ASSERT_IMPL(a_mark_free, cmd_i.mark_step, !occ_q[mark_addr], "marking a held unit")
  `BFOA_ASSERT_IMPL(a_best_fits, found_q,
                    CMP_W'(best_len_q) >= CMP_W'(item_q.request_size), "best run too short")
  `BFOA_ASSERT_IMPL(a_grant_no_free, res_valid_q && res_q.granted,
                    res_q.units_freed == '0, "grant with released units")
  `BFOA_ASSERT(a_idx_bound, idx_q <= POS_W'(MEM_UNITS), "unit index past the map")

endmodule

// File: src/bfoa_ctrl.sv
// Controller state machine that sequences scan, marking and release.
module bfoa_ctrl
  import bfoa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  action_e action_i,
  input  logic    free_on_fail_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = (action_i == ACT_FREE) ? ST_RELEASE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.idx_clr = 1'b1;
        if (sts_i.found) begin
          state_d = ST_MARK;
        end else if (free_on_fail_i) begin
          state_d = ST_RELEASE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MARK: begin
        if (sts_i.mark_go) begin
          cmd_o.mark_step = 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RELEASE: begin
        cmd_o.rel_step = 1'b1;
        if (sts_i.rel_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.emit = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: src/best_fit_owner_allocator_core.sv
// Top level of the best-fit owner allocator: register port, controller, datapath.
// From the accepting edge busy stays high while an allocate word scans and marks its units, a
// free word releases, or a failed allocate releases when free_on_fail is set; the scan and
// the release walk each visit one unit per cycle. done_o is high in the first idle cycle,
// where the next word may already be accepted; the receiver cannot stall. Reset is async.
module best_fit_owner_allocator_core
  import bfoa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Command channel.
  input  logic              start,
  output logic              busy,
  input  item_t             item_i,
  // Result channel: one word per command, valid while done_o is high.
  output logic              done_o,
  output result_t           result_o,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic    free_on_fail_q;
  logic    cfg_wr;
  logic    reg_hit;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Word index sits above the byte offset; only index zero holds a register.
  // Reset leaves every unit free, the block idle and free_on_fail set to one.
  assign reg_hit = (paddr[2] == REG_FREE_ON_FAIL);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DW'(free_on_fail_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_on_fail_q <= FREE_ON_FAIL_RST;
    end else if (cfg_wr && reg_hit) begin
      free_on_fail_q <= pwdata[0];
    end
  end

  // The controller accepts a command only from idle, so busy doubles as
  // the acceptance gate.
  bfoa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .action_i       (item_i.action),
    .free_on_fail_i (free_on_fail_q),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy)
  );

  // The datapath holds the unit map in flip-flops and the owner tags in a
  // single-port-write memory that is read one unit per cycle during release.
  bfoa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (done_o),
    .result_o    (result_o)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the best-fit owner allocator core.
module testbench
  import bfoa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The run is cut off here.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Cycles allowed after the last result, to catch stray strobes.
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned PHASE_WORDS = 137;
  // Byte addresses of the register file: the only register, and an unused slot.
  localparam logic [APB_AW-1:0] FOF_ADDR    = APB_AW'(REG_FREE_ON_FAIL) << 2;
  localparam logic [APB_AW-1:0] UNUSED_ADDR = APB_AW'(4);

  // Every input of the block is known from time zero.
  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start_r = 1'b0;
  item_t             item_r  = '0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;

  logic              busy;
  logic              done_o;
  result_t           result_o;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  best_fit_owner_allocator_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start_r),
    .busy     (busy),
    .item_i   (item_r),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk_i = ~clk_i;

  // Words waiting to be issued, and results expected from the block in order.
  item_t   pending_q[$];
  result_t expected_q[$];

  // Shadow copy of the unit map and the register.
  bit                 unit_taken [MEM_UNITS];
  logic [OWNER_W-1:0] unit_owner [MEM_UNITS];
  bit                 free_on_fail_m;

  int unsigned        mismatch_cnt = 0;
  int unsigned        cycle_cnt    = 0;
  int unsigned        gap_left     = 0;
  bit                 no_idle      = 1'b0;
  logic [OWNER_W-1:0] owner_pool [6];

  // Releases every occupied unit of an owner and returns how many were released.
  function automatic int unsigned release_owner_units(logic [OWNER_W-1:0] owner);
    int unsigned n;
    n = 0;
    for (int i = 0; i < MEM_UNITS; i++) begin
      if (unit_taken[i] && unit_owner[i] == owner) begin
        unit_taken[i] = 1'b0;
        unit_owner[i] = '1;
        n++;
      end
    end
    return n;
  endfunction

  // Applies one word to the shadow map and returns the result it must produce.
  // Allocation takes the shortest free run that is long enough; on a tie the
  // lowest run wins because only a strictly shorter run replaces the best one.
  function automatic result_t apply_alloc_word(item_t it);
    result_t     r;
    int unsigned run_start, run_len, best_len, best_start, freed;
    bit          found;
    r          = '0;
    freed      = 0;
    found      = 1'b0;
    run_start  = 0;
    run_len    = 0;
    best_len   = 0;
    best_start = 0;
    if (it.action == ACT_FREE) begin
      freed = release_owner_units(it.owner_id);
    end else begin
      for (int i = 0; i <= MEM_UNITS; i++) begin
        if (i < MEM_UNITS && !unit_taken[i]) begin
          if (run_len == 0) run_start = i;
          run_len++;
        end else begin
          if (run_len > 0 && run_len >= it.request_size && (!found || run_len < best_len)) begin
            found      = 1'b1;
            best_len   = run_len;
            best_start = run_start;
          end
          run_len = 0;
        end
      end
      if (found) begin
        r.granted    = 1'b1;
        r.start_unit = START_W'(best_start);
        // A zero-size grant marks nothing.
        for (int j = 0; j < it.request_size && best_start + j < MEM_UNITS; j++) begin
          unit_taken[best_start + j] = 1'b1;
          unit_owner[best_start + j] = it.owner_id;
        end
      end else if (free_on_fail_m) begin
        freed = release_owner_units(it.owner_id);
      end
    end
    r.units_freed = (freed > FREED_MAX) ? FREED_MAX : FREED_W'(freed);
    return r;
  endfunction

  // Driver: issues the head of pending_q and keeps start high until the block
  // takes the word. After each accepted word it draws an idle gap that only
  // counts down while the block is not busy, so the next start lands at
  // varying distances from the result strobe. Now and then it switches into
  // a burst mode with no idling at all.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_r && !busy) begin
        expected_q.push_back(apply_alloc_word(pending_q.pop_front()));
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        gap_left = no_idle ? 0 : $urandom_range(0, 8);
      end else if (!start_r && !busy && gap_left > 0) begin
        gap_left--;
      end
      if (pending_q.size() != 0 && gap_left == 0) begin
        start_r <= 1'b1;
        item_r  <= pending_q[0];
      end else begin
        start_r <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word: granted=%0d start_unit=%0d units_freed=%0d",
               result_o.granted, result_o.start_unit, result_o.units_freed);
        mismatch_cnt++;
      end else begin
        if (result_o.granted !== expected_q[0].granted) begin
          $error("granted: expected %0d, got %0d", expected_q[0].granted, result_o.granted);
          mismatch_cnt++;
        end
        if (result_o.start_unit !== expected_q[0].start_unit) begin
          $error("start_unit: expected %0d, got %0d",
                 expected_q[0].start_unit, result_o.start_unit);
          mismatch_cnt++;
        end
        if (result_o.units_freed !== expected_q[0].units_freed) begin
          $error("units_freed: expected %0d, got %0d",
                 expected_q[0].units_freed, result_o.units_freed);
          mismatch_cnt++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_word(action_e act, logic [OWNER_W-1:0] owner, logic [SIZE_W-1:0] size);
    item_t it;
    it.action       = act;
    it.owner_id     = owner;
    it.request_size = size;
    pending_q.push_back(it);
  endtask

  // Returns once every word is issued and its result has come back. Since
  // each word yields exactly one result, the block is idle at that point.
  task automatic wait_idle();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write with a setup and an access phase; the register takes the value at the access edge.
  task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == FOF_ADDR) free_on_fail_m = data[0];
  endtask

  // Reads the register back and checks bit 0 against the shadow copy.
  task automatic reg_check();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FOF_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== free_on_fail_m) begin
      $error("free_on_fail: expected %0d, got %0d", free_on_fail_m, prdata[0]);
      mismatch_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random phase. Most words allocate small runs for a handful of owners,
  // so the map fills, fragments and produces ties; frees punch holes back in.
  // A minority asks for zero units, for large runs, or for sizes beyond the
  // map, which drives the failure and release paths.
  task automatic random_phase(int unsigned count);
    logic [SIZE_W-1:0] size;
    int unsigned       pick;
    owner_pool[0] = '0;
    owner_pool[1] = '1;
    for (int i = 2; i < 6; i++) owner_pool[i] = OWNER_W'($urandom);
    @(negedge clk_i);
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) size = SIZE_W'($urandom_range(1, 12));
      else if (pick < 75) size = SIZE_W'($urandom_range(13, 64));
      else if (pick < 85) size = '0;
      else size = SIZE_W'($urandom_range(65, 127));
      if ($urandom_range(0, 9) == 0) begin
        // Stray owner that rarely holds anything.
        add_word($urandom_range(0, 1) ? ACT_FREE : ACT_ALLOC, OWNER_W'($urandom), size);
      end else begin
        add_word(($urandom_range(0, 3) == 0) ? ACT_FREE : ACT_ALLOC,
                 owner_pool[$urandom_range(0, 5)], size);
      end
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < MEM_UNITS; i++) begin
      unit_taken[i] = 1'b0;
      unit_owner[i] = '1;
    end
    free_on_fail_m = FREE_ON_FAIL_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words with the register at its reset value.
    add_word(ACT_ALLOC, 16'h0001, 7'd0);   // zero size on an empty map
    add_word(ACT_ALLOC, 16'h0001, 7'd64);  // fills the whole map
    add_word(ACT_ALLOC, 16'h0002, 7'd1);   // map full: fails, owner holds nothing
    add_word(ACT_ALLOC, 16'h0002, 7'd0);   // zero size with no free unit fails
    add_word(ACT_FREE,  16'h0001, 7'd127); // releases all units, size ignored
    add_word(ACT_FREE,  16'h0001, 7'd5);   // nothing left to release
    add_word(ACT_ALLOC, 16'hFFFF, 7'd127); // oversized request
    add_word(ACT_ALLOC, 16'hFFFF, 7'd65);  // one unit too many
    add_word(ACT_ALLOC, 16'hAAAA, 7'd10);
    add_word(ACT_ALLOC, 16'h5555, 7'd5);
    add_word(ACT_ALLOC, 16'hFFFF, 7'd20);  // reserved tag used as a real owner
    add_word(ACT_ALLOC, 16'hAAAA, 7'd4);
    add_word(ACT_FREE,  16'h5555, 7'd0);   // opens a five-unit hole
    add_word(ACT_ALLOC, 16'h1234, 7'd3);   // best fit goes into that hole
    add_word(ACT_FREE,  16'hFFFF, 7'd0);   // reserved tag releases its units
    add_word(ACT_ALLOC, 16'h0F0F, 7'd22);  // exact fit
    add_word(ACT_ALLOC, 16'h0F0F, 7'd30);  // fails and releases the owner
    add_word(ACT_FREE,  16'hAAAA, 7'd1);
    add_word(ACT_ALLOC, 16'h7777, 7'd41);  // leaves two free runs of equal length
    add_word(ACT_ALLOC, 16'h8888, 7'd7);   // tie goes to the lower run
    add_word(ACT_ALLOC, 16'h8888, 7'd0);   // zero size picks the shortest run
    wait_idle();
    random_phase(PHASE_WORDS);

    // Failures keep the map unchanged.
    reg_write(FOF_ADDR, $urandom & ~32'h1);
    reg_check();
    random_phase(PHASE_WORDS);

    // A write to an unused address must not touch the register.
    reg_write(UNUSED_ADDR, 32'h1);
    reg_check();
    reg_write(FOF_ADDR, $urandom | 32'h1);
    reg_check();
    random_phase(PHASE_WORDS);
    reg_write(FOF_ADDR, 32'h0);
    random_phase(PHASE_WORDS);
    reg_write(FOF_ADDR, 32'hFFFF_FFFF);
    reg_check();
    random_phase(PHASE_WORDS);

    // Watch for stray result words before closing out.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
